// ----- design/tpt_pkg.sv -----
// ---------------------------------------------------------------------------
// Touch path trace checker package
// Shared widths, codes and field positions for the checker and its assertions.
// ---------------------------------------------------------------------------
package tpt_pkg;

  localparam int unsigned MaxDots   = 32;
  localparam int unsigned CoordBits = 9;
  localparam int unsigned IdxBits   = 5;
  localparam int unsigned CntBits   = 6;

  // Input kinds, carried on tuser.
  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_TOUCH = 2'd1,
    ACT_LIFT  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_LOADED  = 3'd0,
    ST_IGNORED = 3'd1,
    ST_STARTED = 3'd2,
    ST_ONPATH  = 3'd3,
    ST_OFFPATH = 3'd4,
    ST_LIFTOFF = 3'd5,
    ST_PASSED  = 3'd6,
    ST_SPARE   = 3'd7
  } status_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_DOT_COUNT = 3'd0,
    REG_CORRIDOR  = 3'd1,
    REG_CAPTURE   = 3'd2,
    REG_MIN_STEP  = 3'd3
  } cfg_reg_e;

  // Result tdata bit positions.
  localparam int unsigned OutStatusLsb = 0;
  localparam int unsigned OutProgLsb   = 3;
  localparam int unsigned OutBestLsb   = 9;
  localparam int unsigned OutTrkBit    = 15;
  localparam int unsigned OutDoneBit   = 16;
  localparam int unsigned OutAccBit    = 17;
  localparam int unsigned OutBits      = 24;
  localparam int unsigned InBits       = 24;

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic signed [CoordBits:0] diff_t;

endpackage

// ----- design/touch_path_trace_checker.sv -----
// ---------------------------------------------------------------------------
// Touch path trace checker
// Follows one touch stroke along a polyline of dots held in a local memory.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Contents (lowest bit first)
//  s_axis    in         tuser: action; tdata: dot_index, pos_x, pos_y
//  m_axis    out        tdata: status, progress, best_reached, is_tracking,
//                              is_done, trace_accepted
//  cfg       in         write enable, register index, 8-bit data
//
// Items are handled one at a time by a sequencer around a dot memory with
// one write port and one registered read port. A liftoff or ignored item
// goes straight to the result, a load writes its dot, and a stroke start
// reads dot 0 and compares it. A tracked sample checks up to LOOKAHEAD+2
// segments, runs one 9-step divider twice for each segment whose projection
// needs it, and reads each captured dot in turn.
// Reset is asynchronous and active low; the dot memory is not cleared and
// entries must be loaded before use. The input is taken only in the idle
// state; a result waits in the output register while the next item enters,
// and the sequencer stalls only if a second result is ready before the
// first transfer has completed.
module touch_path_trace_checker #(
  parameter int unsigned LOOKAHEAD      = 3,
  parameter int unsigned TRACE_CAPACITY = 640
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // dot_index [4:0], pos_x [13:5], pos_y [22:14]
  input  logic [tpt_pkg::InBits-1:0]  s_axis_tdata_i,
  // action [1:0]
  input  logic [1:0]                  s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // status [2:0], progress [8:3], best_reached [14:9], is_tracking [15],
  // is_done [16], trace_accepted [17]
  output logic [tpt_pkg::OutBits-1:0] m_axis_tdata_o,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_idx_i,
  input  logic [7:0]                  cfg_wdata_i
);
  import tpt_pkg::*;

  localparam int unsigned TcBits = $clog2(TRACE_CAPACITY + 1);

  typedef enum logic [19:0] {
    S_IDLE    = 20'h00001,
    S_ST_RD   = 20'h00002,
    S_ST_CMP  = 20'h00004,
    S_SEG_CHK = 20'h00008,
    S_SEG_RDA = 20'h00010,
    S_SEG_RDB = 20'h00020,
    S_SEG_LEN = 20'h00040,
    S_SEG_T   = 20'h00080,
    S_SEG_DEC = 20'h00100,
    S_SEG_MUL = 20'h00200,
    S_SEG_DIV = 20'h00400,
    S_SEG_DST = 20'h00800,
    S_SEG_CMP = 20'h01000,
    S_EVAL    = 20'h02000,
    S_CAP_CHK = 20'h04000,
    S_CAP_RD  = 20'h08000,
    S_CAP_CMP = 20'h10000,
    S_TR_DIFF = 20'h20000,
    S_TR_CHK  = 20'h40000,
    S_EMIT    = 20'h80000
  } state_e;

  // Control state.
  state_e              state_q, state_d;
  logic                trk_q, trk_d;
  logic [CntBits-1:0]  nt_q, nt_d;
  logic [CntBits-1:0]  bt_q, bt_d;
  logic                done_q, done_d;
  logic [TcBits-1:0]   tcnt_q, tcnt_d;
  coord_t              lastx_q, lastx_d, lasty_q, lasty_d;
  logic [CntBits-1:0]  dcnt_q, dcnt_d;
  logic [15:0]         cor_sq_q, cor_sq_d, cap_sq_q, cap_sq_d, stp_sq_q, stp_sq_d;
  logic                mvld_q, mvld_d;

  // Working registers of the item in flight.
  action_e             act_q, act_d;
  logic [IdxBits-1:0]  idx_q, idx_d;
  coord_t              px_q, px_d, py_q, py_d;
  logic [CntBits-1:0]  e_q, e_d;
  logic                found_q, found_d;
  logic [20:0]         bestd_q, bestd_d;
  logic [CntBits-1:0]  bend_q, bend_d;
  coord_t              ax_q, ax_d, ay_q, ay_d;
  diff_t               abx_q, abx_d, aby_q, aby_d, apx_q, apx_d, apy_q, apy_d;
  logic [19:0]         len_q, len_d;
  logic signed [20:0]  t_q, t_d;
  logic                divy_q, divy_d, neg_q, neg_d;
  logic [19:0]         rem_q, rem_d;
  logic [8:0]          low_q, low_d, quo_q, quo_d;
  logic [3:0]          cnt_q, cnt_d;
  diff_t               cx_q, cx_d, cy_q, cy_d;
  logic [20:0]         dist_q, dist_d;
  diff_t               ddx_q, ddx_d, ddy_q, ddy_d;
  status_e             rst_q, rst_d;
  logic                racc_q, racc_d;
  logic [OutBits-1:0]  mdata_q, mdata_d;

  // Dot memory: {y, x} per entry.
  logic [2*CoordBits-1:0] dot_mem [MaxDots];
  logic [2*CoordBits-1:0] rdata_q;
  logic                   rd_en, wr_en;
  logic [IdxBits-1:0]     rd_addr;
  coord_t                 rdx, rdy;

  assign rdx = rdata_q[CoordBits-1:0];
  assign rdy = rdata_q[2*CoordBits-1:CoordBits];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      dot_mem[idx_q] <= {py_q, px_q};
    end
    if (rd_en) begin
      rdata_q <= dot_mem[rd_addr];
    end
  end

  // Combinational helpers.
  logic [CntBits-1:0]  n_eff;
  logic [CntBits:0]    la_lim;
  logic signed [19:0]  sq_a, sq_b;
  logic [19:0]         ddsq;
  logic signed [10:0]  dsx, dsy;
  logic signed [21:0]  dsq_a, dsq_b;
  logic [8:0]          op_abs;
  diff_t               op_sel;
  logic [28:0]         mag;
  logic [20:0]         rem_try;
  logic                rem_ge;
  logic [8:0]          quo_nxt;
  diff_t               quo_sgn;
  logic                in_acc;
  logic                trc_ok;

  assign n_eff  = (dcnt_q > CntBits'(MaxDots)) ? CntBits'(MaxDots) : dcnt_q;
  assign la_lim = {1'b0, nt_q} + (CntBits+1)'(LOOKAHEAD);

  assign sq_a  = ddx_q * ddx_q;
  assign sq_b  = ddy_q * ddy_q;
  assign ddsq  = 20'(sq_a) + 20'(sq_b);

  assign dsx   = 11'(apx_q) - 11'(cx_q);
  assign dsy   = 11'(apy_q) - 11'(cy_q);
  assign dsq_a = dsx * dsx;
  assign dsq_b = dsy * dsy;

  assign op_sel = divy_q ? aby_q : abx_q;
  assign op_abs = op_sel[CoordBits] ? 9'(-op_sel) : 9'(op_sel);
  assign mag    = op_abs * t_q[19:0];

  assign rem_try = {rem_q, low_q[8]};
  assign rem_ge  = rem_try >= {1'b0, len_q};
  assign quo_nxt = {quo_q[7:0], rem_ge};
  assign quo_sgn = neg_q ? -diff_t'({1'b0, quo_nxt}) : diff_t'({1'b0, quo_nxt});

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign trc_ok = (tcnt_q < TcBits'(TRACE_CAPACITY))
               && ((tcnt_q == '0) || ({4'd0, stp_sq_q} <= ddsq));

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = mvld_q;
  assign m_axis_tdata_o  = mdata_q;

  always_comb begin
    state_d = state_q;  trk_d = trk_q;  nt_d = nt_q;  bt_d = bt_q;
    done_d = done_q;  tcnt_d = tcnt_q;  lastx_d = lastx_q;  lasty_d = lasty_q;
    dcnt_d = dcnt_q;  cor_sq_d = cor_sq_q;  cap_sq_d = cap_sq_q;
    stp_sq_d = stp_sq_q;  mvld_d = mvld_q;
    act_d = act_q;  idx_d = idx_q;  px_d = px_q;  py_d = py_q;  e_d = e_q;
    found_d = found_q;  bestd_d = bestd_q;  bend_d = bend_q;
    ax_d = ax_q;  ay_d = ay_q;  abx_d = abx_q;  aby_d = aby_q;
    apx_d = apx_q;  apy_d = apy_q;  len_d = len_q;  t_d = t_q;
    divy_d = divy_q;  neg_d = neg_q;  rem_d = rem_q;  low_d = low_q;
    quo_d = quo_q;  cnt_d = cnt_q;  cx_d = cx_q;  cy_d = cy_q;
    dist_d = dist_q;  ddx_d = ddx_q;  ddy_d = ddy_q;
    rst_d = rst_q;  racc_d = racc_q;  mdata_d = mdata_q;
    rd_en = 1'b0;  rd_addr = '0;  wr_en = 1'b0;

    if (mvld_q && m_axis_tready_i) begin
      mvld_d = 1'b0;
    end

    // Register writes are to arrive only while idle; the block itself does not enforce this. Squares are kept ready.
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DOT_COUNT: dcnt_d   = cfg_wdata_i[CntBits-1:0];
        REG_CORRIDOR:  cor_sq_d = cfg_wdata_i * cfg_wdata_i;
        REG_CAPTURE:   cap_sq_d = cfg_wdata_i * cfg_wdata_i;
        REG_MIN_STEP:  stp_sq_d = cfg_wdata_i * cfg_wdata_i;
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          act_d  = action_e'(s_axis_tuser_i);
          idx_d  = s_axis_tdata_i[IdxBits-1:0];
          px_d   = s_axis_tdata_i[IdxBits +: CoordBits];
          py_d   = s_axis_tdata_i[IdxBits+CoordBits +: CoordBits];
          racc_d = 1'b0;
          rst_d  = ST_IGNORED;
          state_d = S_EMIT;
          if (action_e'(s_axis_tuser_i) == ACT_LOAD) begin
            rst_d   = ST_LOADED;
            state_d = S_ST_RD;
            act_d   = ACT_LOAD;
          end else if (action_e'(s_axis_tuser_i) == ACT_NONE || done_q) begin
            rst_d = ST_IGNORED;
          end else if (action_e'(s_axis_tuser_i) == ACT_LIFT) begin
            nt_d  = '0;
            trk_d = 1'b0;
            rst_d = ST_LIFTOFF;
          end else if (!trk_q) begin
            rd_en   = 1'b1;
            rd_addr = '0;
            state_d = S_ST_RD;
          end else begin
            found_d = 1'b0;
            bend_d  = nt_q;
            e_d     = (nt_q >= CntBits'(2)) ? nt_q - CntBits'(1) : nt_q;
            state_d = S_SEG_CHK;
          end
        end
      end

      S_ST_RD: begin
        if (act_q == ACT_LOAD) begin
          // The memory write is made here, off the input path.
          wr_en   = 1'b1;
          state_d = S_EMIT;
        end else begin
          ddx_d   = diff_t'({1'b0, px_q}) - diff_t'({1'b0, rdx});
          ddy_d   = diff_t'({1'b0, py_q}) - diff_t'({1'b0, rdy});
          state_d = S_ST_CMP;
        end
      end

      S_ST_CMP: begin
        // A new stroke always takes its first trace point.
        if (ddsq <= {4'd0, cor_sq_q}) begin
          trk_d   = 1'b1;
          nt_d    = CntBits'(1);
          tcnt_d  = TcBits'(1);
          lastx_d = px_q;
          lasty_d = py_q;
          racc_d  = 1'b1;
          rst_d   = ST_STARTED;
        end
        state_d = S_EMIT;
      end

      S_SEG_CHK: begin
        if (e_q < n_eff && {1'b0, e_q} <= la_lim) begin
          if (e_q == '0) begin
            e_d = e_q + CntBits'(1);
          end else begin
            rd_en   = 1'b1;
            rd_addr = IdxBits'(e_q - CntBits'(1));
            state_d = S_SEG_RDA;
          end
        end else begin
          state_d = S_EVAL;
        end
      end

      S_SEG_RDA: begin
        ax_d    = rdx;
        ay_d    = rdy;
        apx_d   = diff_t'({1'b0, px_q}) - diff_t'({1'b0, rdx});
        apy_d   = diff_t'({1'b0, py_q}) - diff_t'({1'b0, rdy});
        rd_en   = 1'b1;
        rd_addr = e_q[IdxBits-1:0];
        state_d = S_SEG_RDB;
      end

      S_SEG_RDB: begin
        abx_d   = diff_t'({1'b0, rdx}) - diff_t'({1'b0, ax_q});
        aby_d   = diff_t'({1'b0, rdy}) - diff_t'({1'b0, ay_q});
        state_d = S_SEG_LEN;
      end

      S_SEG_LEN: begin
        len_d   = 20'(abx_q * abx_q) + 20'(aby_q * aby_q);
        state_d = S_SEG_T;
      end

      S_SEG_T: begin
        t_d     = 21'(apx_q * abx_q) + 21'(apy_q * aby_q);
        state_d = S_SEG_DEC;
      end

      S_SEG_DEC: begin
        cx_d    = '0;
        cy_d    = '0;
        state_d = S_SEG_DST;
        if (len_q != '0 && t_q >= $signed({1'b0, len_q})) begin
          cx_d = abx_q;
          cy_d = aby_q;
        end else if (len_q != '0 && t_q > 0) begin
          divy_d  = 1'b0;
          state_d = S_SEG_MUL;
        end
      end

      S_SEG_MUL: begin
        // Quotient is below the component magnitude, so nine steps suffice.
        neg_d   = op_sel[CoordBits];
        rem_d   = mag[28:9];
        low_d   = mag[8:0];
        quo_d   = '0;
        cnt_d   = '0;
        state_d = S_SEG_DIV;
      end

      S_SEG_DIV: begin
        rem_d = rem_ge ? 20'(rem_try - {1'b0, len_q}) : rem_try[19:0];
        low_d = {low_q[7:0], 1'b0};
        quo_d = quo_nxt;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd8) begin
          if (!divy_q) begin
            cx_d    = quo_sgn;
            divy_d  = 1'b1;
            state_d = S_SEG_MUL;
          end else begin
            cy_d    = quo_sgn;
            state_d = S_SEG_DST;
          end
        end
      end

      S_SEG_DST: begin
        dist_d  = 21'(dsq_a) + 21'(dsq_b);
        state_d = S_SEG_CMP;
      end

      S_SEG_CMP: begin
        if (!found_q || dist_q < bestd_q) begin
          found_d = 1'b1;
          bestd_d = dist_q;
          bend_d  = e_q;
        end
        e_d     = e_q + CntBits'(1);
        state_d = S_SEG_CHK;
      end

      S_EVAL: begin
        if (!found_q || bestd_q > {5'd0, cor_sq_q}) begin
          nt_d    = '0;
          trk_d   = 1'b0;
          rst_d   = ST_OFFPATH;
          state_d = S_EMIT;
        end else begin
          if (bend_q > nt_q) begin
            nt_d = bend_q;
          end
          state_d = S_CAP_CHK;
        end
      end

      S_CAP_CHK: begin
        if (nt_q < n_eff) begin
          rd_en   = 1'b1;
          rd_addr = nt_q[IdxBits-1:0];
          state_d = S_CAP_RD;
        end else begin
          state_d = S_TR_DIFF;
        end
      end

      S_CAP_RD: begin
        ddx_d   = diff_t'({1'b0, px_q}) - diff_t'({1'b0, rdx});
        ddy_d   = diff_t'({1'b0, py_q}) - diff_t'({1'b0, rdy});
        state_d = S_CAP_CMP;
      end

      S_CAP_CMP: begin
        if (ddsq <= {4'd0, cap_sq_q}) begin
          nt_d    = nt_q + CntBits'(1);
          state_d = S_CAP_CHK;
        end else begin
          state_d = S_TR_DIFF;
        end
      end

      S_TR_DIFF: begin
        ddx_d   = diff_t'({1'b0, px_q}) - diff_t'({1'b0, lastx_q});
        ddy_d   = diff_t'({1'b0, py_q}) - diff_t'({1'b0, lasty_q});
        state_d = S_TR_CHK;
      end

      S_TR_CHK: begin
        if (trc_ok) begin
          lastx_d = px_q;
          lasty_d = py_q;
          tcnt_d  = tcnt_q + TcBits'(1);
          racc_d  = 1'b1;
        end
        if (nt_q > bt_q) begin
          bt_d = nt_q;
        end
        if (nt_q == n_eff) begin
          done_d = 1'b1;
          rst_d  = ST_PASSED;
        end else begin
          rst_d  = ST_ONPATH;
        end
        state_d = S_EMIT;
      end

      S_EMIT: begin
        if (!mvld_q || m_axis_tready_i) begin
          mvld_d  = 1'b1;
          mdata_d = '0;
          mdata_d[OutStatusLsb +: 3]     = rst_q;
          mdata_d[OutProgLsb +: CntBits] = nt_q;
          mdata_d[OutBestLsb +: CntBits] = bt_q;
          mdata_d[OutTrkBit]             = trk_q;
          mdata_d[OutDoneBit]            = done_q;
          mdata_d[OutAccBit]             = racc_q;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      trk_q    <= 1'b0;
      nt_q     <= '0;
      bt_q     <= '0;
      done_q   <= 1'b0;
      tcnt_q   <= '0;
      lastx_q  <= '0;
      lasty_q  <= '0;
      dcnt_q   <= CntBits'(25);
      cor_sq_q <= 16'd196;
      cap_sq_q <= 16'd196;
      stp_sq_q <= 16'd9;
      mvld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      trk_q    <= trk_d;
      nt_q     <= nt_d;
      bt_q     <= bt_d;
      done_q   <= done_d;
      tcnt_q   <= tcnt_d;
      lastx_q  <= lastx_d;
      lasty_q  <= lasty_d;
      dcnt_q   <= dcnt_d;
      cor_sq_q <= cor_sq_d;
      cap_sq_q <= cap_sq_d;
      stp_sq_q <= stp_sq_d;
      mvld_q   <= mvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;    idx_q   <= idx_d;    px_q    <= px_d;    py_q  <= py_d;
    e_q     <= e_d;      found_q <= found_d;  bestd_q <= bestd_d; bend_q <= bend_d;
    ax_q    <= ax_d;     ay_q    <= ay_d;     abx_q   <= abx_d;   aby_q <= aby_d;
    apx_q   <= apx_d;    apy_q   <= apy_d;    len_q   <= len_d;   t_q   <= t_d;
    divy_q  <= divy_d;   neg_q   <= neg_d;    rem_q   <= rem_d;   low_q <= low_d;
    quo_q   <= quo_d;    cnt_q   <= cnt_d;    cx_q    <= cx_d;    cy_q  <= cy_d;
    dist_q  <= dist_d;   ddx_q   <= ddx_d;    ddy_q   <= ddy_d;
    rst_q   <= rst_d;    racc_q  <= racc_d;   mdata_q <= mdata_d;
  end

endmodule

// ----- design/tpt_checker.sv -----
// ---------------------------------------------------------------------------
// Touch path trace checker port assertions
// Watches the top level's ports and flags handshake and result slips.
// ---------------------------------------------------------------------------
module tpt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid_i,
  input logic                        s_axis_tready_o,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i,
  input logic [tpt_pkg::OutBits-1:0] m_axis_tdata_o
);
  import tpt_pkg::*;

  logic out_xfer;
  logic done_seen_q;

  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_seen_q <= 1'b0;
    end else if (out_xfer && m_axis_tdata_o[OutDoneBit]) begin
      done_seen_q <= 1'b1;
    end
  end

  // A result offered stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result withdrawn before transfer");

  // Items are handled one at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while an item is in flight");

  // Once passed, the block stays in the done state.
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && done_seen_q |-> m_axis_tdata_o[OutDoneBit])
    else $error("done flag cleared after pass");

  // A pass result always reports done, and the best progress never trails it.
  // The best may lie ahead when an earlier, longer path was followed further.
  a_pass_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && (m_axis_tdata_o[OutStatusLsb +: 3] == ST_PASSED)
      |-> m_axis_tdata_o[OutDoneBit]
       && (m_axis_tdata_o[OutBestLsb +: CntBits]
           >= m_axis_tdata_o[OutProgLsb +: CntBits]))
    else $error("pass result without done state");

endmodule

bind touch_path_trace_checker tpt_checker u_tpt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
